### rtl/core/bltbs_pkg.sv
// Shared types and constants of the top-band battery level smoother.
package bltbs_pkg;

  // Band store geometry
  localparam int BAND_ENTRIES = 11;
  localparam int IDX_W        = $clog2(BAND_ENTRIES);

  // Field widths
  localparam int PCT_W      = 7;
  localparam int TIME_W     = 32;
  localparam int HOLD_W     = 17;
  localparam int RT_W       = 16;
  localparam int LEVEL_W    = 14;
  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = 17;

  // Shared divider: two quotient bits per cycle
  localparam int DIV_W     = 34;
  localparam int DEN_W     = 16;
  localparam int DIV_STEPS = DIV_W / 2;
  localparam int CNT_W     = $clog2(DIV_STEPS + 1);

  // Percent constants
  localparam logic [PCT_W-1:0] BAND_BASE   = 7'd90;
  localparam logic [PCT_W-1:0] FULL_PCT    = 7'd100;
  localparam logic [PCT_W-1:0] EMPTY_SHOWN = 7'd1;
  localparam logic [PCT_W-1:0] PCT_SCALE   = 7'd100;

  // Register reset values and time base
  localparam logic [HOLD_W-1:0] HOLD_RESET    = 17'd1800;
  localparam logic [RT_W-1:0]   RUNTIME_RESET = 16'd400;
  localparam logic [DEN_W-1:0]  SECS_PER_MIN  = 16'd60;

  typedef enum logic [3:0] {
    S_IDLE,
    S_CLASS,
    S_RD_PREV,
    S_DIFF,
    S_DECIDE,
    S_WR_PREV,
    S_DIV1,
    S_LOAD2,
    S_DIV2,
    S_DROP,
    S_OUT
  } state_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_STEP_HOLD    = 1'b0,
    REG_FULL_RUNTIME = 1'b1
  } cfg_reg_t;

  typedef struct packed {
    logic             start;
    logic [DIV_W-1:0] num;
    logic [DEN_W-1:0] den;
  } div_req_t;

  typedef struct packed {
    logic             busy;
    logic [DIV_W-1:0] quot;
  } div_rsp_t;

endpackage

### rtl/core/bltbs_div.sv
// Shared restoring divider, two quotient bits per cycle.
module bltbs_div (
  input  logic                clk,
  input  logic                rst,
  input  bltbs_pkg::div_req_t req,
  output bltbs_pkg::div_rsp_t rsp
);
  import bltbs_pkg::*;

  logic [DIV_W-1:0] num;
  logic [DEN_W-1:0] den;
  logic [DEN_W-1:0] rem;
  logic [CNT_W-1:0] cnt;
  logic [DEN_W:0]   t1;
  logic [DEN_W:0]   t2;
  logic [DEN_W-1:0] rem1;
  logic [DEN_W-1:0] rem2;
  logic             q1;
  logic             q2;

  // Two dependent compare/subtract steps; remainder stays below the divisor
  always_comb begin
    t1   = {rem, num[DIV_W-1]};
    q1   = (t1 >= {1'b0, den});
    rem1 = q1 ? DEN_W'(t1 - {1'b0, den}) : t1[DEN_W-1:0];
    t2   = {rem1, num[DIV_W-2]};
    q2   = (t2 >= {1'b0, den});
    rem2 = q2 ? DEN_W'(t2 - {1'b0, den}) : t2[DEN_W-1:0];
  end

  // Step counter
  always_ff @(posedge clk) begin
    if (rst) begin
      cnt <= '0;
    end else if (req.start) begin
      cnt <= CNT_W'(DIV_STEPS);
    end else if (cnt != '0) begin
      cnt <= cnt - CNT_W'(1);
    end
  end

  // Dividend shifts out, quotient bits shift in
  always_ff @(posedge clk) begin
    if (req.start) begin
      num <= req.num;
      den <= req.den;
      rem <= '0;
    end else if (cnt != '0) begin
      num <= {num[DIV_W-3:0], q1, q2};
      rem <= rem2;
    end
  end

  assign rsp.busy = (cnt != '0);
  assign rsp.quot = num;

endmodule

### rtl/core/battery_level_top_band_smoother.sv
// Top level: battery level smoother for the 90..99 percent charge band.
//
//  channel  | handshake                 | payload
//  ---------+---------------------------+------------------------------------------
//  gauge    | gauge_valid / gauge_stall | gauge_percent, charging, now_seconds
//  level    | level_valid / level_stall | level_hundredths
//  cfg      | cfg_valid / cfg_ready     | cfg_index, cfg_data
//
// One transaction at a time. Readings outside the band and new percents while
// charging go from classification straight to the output state, other readings in
// the band first read the band store for the current and the previous percent,
// and discharging readings under a raised level make two passes through the
// shared divider (seconds to minutes, then the percent drop). Synchronous reset
// clears the band store through valid bits; the block is ready the cycle after
// reset. A stalled result stays in the output register while the next reading
// is already taken and worked on.
module battery_level_top_band_smoother (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             gauge_valid,
  output logic                             gauge_stall,
  input  logic [bltbs_pkg::PCT_W-1:0]      gauge_percent,
  input  logic                             charging,
  input  logic [bltbs_pkg::TIME_W-1:0]     now_seconds,
  output logic                             level_valid,
  input  logic                             level_stall,
  output logic [bltbs_pkg::LEVEL_W-1:0]    level_hundredths,
  input  logic                             cfg_valid,
  output logic                             cfg_ready,
  input  logic [bltbs_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [bltbs_pkg::CFG_DATA_W-1:0] cfg_data
);
  import bltbs_pkg::*;

  state_t state, state_next;

  // Captured reading and settings
  logic [PCT_W-1:0]  pct;
  logic              chg;
  logic [TIME_W-1:0] now_t;
  logic [PCT_W-1:0]  last_percent;
  logic [HOLD_W-1:0] step_hold;
  logic [RT_W-1:0]   full_runtime;

  // Band store
  logic [TIME_W-1:0]       start_mem [BAND_ENTRIES];
  logic [PCT_W-1:0]        level_mem [BAND_ENTRIES];
  logic [BAND_ENTRIES-1:0] start_vld;
  logic [BAND_ENTRIES-1:0] level_vld;
  logic [TIME_W-1:0]       rd_start;
  logic [PCT_W-1:0]        rd_level;

  // Working registers
  logic [TIME_W-1:0] cur_start;
  logic [PCT_W-1:0]  cur_level;
  logic [TIME_W-1:0] elapsed;
  logic [TIME_W-1:0] ref_span;
  logic [DIV_W-1:0]  prod;
  logic [PCT_W-1:0]  res_level;

  // Control from the sequencer
  logic [IDX_W-1:0]  band_idx;
  logic [IDX_W-1:0]  prev_idx;
  logic [PCT_W-1:0]  band_off;
  logic [IDX_W-1:0]  rd_addr;
  logic              start_we;
  logic [IDX_W-1:0]  start_waddr;
  logic [TIME_W-1:0] start_wdata;
  logic              level_we;
  logic [PCT_W-1:0]  level_wdata;
  logic              res_ld;
  logic [PCT_W-1:0]  res_next;
  logic              last_ld;
  logic              out_ld;
  logic [RT_W-1:0]   rt_eff;
  logic [PCT_W-1:0]  bump_level;
  logic [TIME_W-1:0] twice_ref;
  logic [PCT_W-1:0]  new_level;
  logic              out_free;
  div_req_t          div_req;
  div_rsp_t          div_rsp;

  bltbs_div u_div (
    .clk (clk),
    .rst (rst),
    .req (div_req),
    .rsp (div_rsp)
  );

  // Derived values
  assign band_off    = pct - BAND_BASE;
  assign band_idx    = band_off[IDX_W-1:0];
  assign prev_idx    = (band_idx == '0) ? '0 : band_idx - IDX_W'(1);
  assign rt_eff      = (full_runtime == '0) ? RT_W'(1) : full_runtime;
  assign bump_level  = (cur_level >= FULL_PCT) ? FULL_PCT : cur_level + PCT_W'(1);
  assign twice_ref   = {ref_span[TIME_W-2:0], 1'b0};
  assign out_free    = !level_valid || !level_stall;
  assign gauge_stall = (state != S_IDLE);
  assign cfg_ready   = 1'b1;

  // Level after the discharge drop, never below the gauge reading
  always_comb begin
    if (div_rsp.quot < DIV_W'(cur_level)) begin
      new_level = cur_level - div_rsp.quot[PCT_W-1:0];
    end else begin
      new_level = '0;
    end
    if (new_level < pct) begin
      new_level = pct;
    end
  end

  // Sequencer: next state and control
  always_comb begin
    state_next  = state;
    rd_addr     = band_idx;
    start_we    = 1'b0;
    start_waddr = band_idx;
    start_wdata = now_t;
    level_we    = 1'b0;
    level_wdata = pct;
    res_ld      = 1'b0;
    res_next    = pct;
    last_ld     = 1'b0;
    out_ld      = 1'b0;
    div_req     = '0;
    unique case (state)
      S_IDLE: begin
        if (gauge_valid) begin
          state_next = S_CLASS;
        end
      end
      S_CLASS: begin
        res_ld = 1'b1;
        state_next = S_OUT;
        if (pct == '0 && !chg) begin
          res_next = EMPTY_SHOWN;
        end else if (pct >= FULL_PCT) begin
          res_next = FULL_PCT;
        end else if (pct < BAND_BASE) begin
          res_next = pct;
        end else if (chg && last_percent != pct) begin
          // New percent while charging: restart this band
          start_we = 1'b1;
          level_we = 1'b1;
          last_ld  = 1'b1;
        end else begin
          res_ld     = 1'b0;
          state_next = S_RD_PREV;
        end
      end
      S_RD_PREV: begin
        rd_addr    = prev_idx;
        state_next = S_DIFF;
      end
      S_DIFF: begin
        state_next = S_DECIDE;
      end
      S_DECIDE: begin
        res_ld     = 1'b1;
        res_next   = cur_level;
        state_next = S_OUT;
        if (chg) begin
          if (band_idx < IDX_W'(2)) begin
            if (elapsed > TIME_W'(step_hold)) begin
              start_we    = 1'b1;
              level_we    = 1'b1;
              level_wdata = bump_level;
              res_next    = bump_level;
            end
          end else if (elapsed > ref_span && elapsed > twice_ref) begin
            // Held past twice the previous band's span
            start_we    = 1'b1;
            level_we    = 1'b1;
            level_wdata = bump_level;
            res_next    = bump_level;
            state_next  = S_WR_PREV;
          end
        end else if (cur_level > pct) begin
          res_ld        = 1'b0;
          div_req.start = 1'b1;
          div_req.num   = DIV_W'(elapsed);
          div_req.den   = SECS_PER_MIN;
          state_next    = S_DIV1;
        end else begin
          res_next = pct;
        end
      end
      S_WR_PREV: begin
        start_we    = 1'b1;
        start_waddr = prev_idx;
        start_wdata = now_t - ref_span;
        state_next  = S_OUT;
      end
      S_DIV1: begin
        if (!div_rsp.busy) begin
          state_next = S_LOAD2;
        end
      end
      S_LOAD2: begin
        // Ceiling division: add divisor minus one
        div_req.start = 1'b1;
        div_req.num   = prod + DIV_W'(rt_eff) - DIV_W'(1);
        div_req.den   = rt_eff;
        state_next    = S_DIV2;
      end
      S_DIV2: begin
        if (!div_rsp.busy) begin
          state_next = S_DROP;
        end
      end
      S_DROP: begin
        level_we    = 1'b1;
        level_wdata = new_level;
        res_ld      = 1'b1;
        res_next    = new_level;
        state_next  = S_OUT;
      end
      S_OUT: begin
        if (out_free) begin
          out_ld     = 1'b1;
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  // State register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Control state: settings, last percent, valid bits, output valid
  always_ff @(posedge clk) begin
    if (rst) begin
      step_hold    <= HOLD_RESET;
      full_runtime <= RUNTIME_RESET;
      last_percent <= '0;
      start_vld    <= '0;
      level_vld    <= '0;
      level_valid  <= 1'b0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        unique case (cfg_reg_t'(cfg_index))
          REG_STEP_HOLD:    step_hold    <= cfg_data[HOLD_W-1:0];
          REG_FULL_RUNTIME: full_runtime <= cfg_data[RT_W-1:0];
          default:          ;
        endcase
      end
      if (last_ld) begin
        last_percent <= pct;
      end
      if (start_we) begin
        start_vld[start_waddr] <= 1'b1;
      end
      if (level_we) begin
        level_vld[band_idx] <= 1'b1;
      end
      if (out_ld) begin
        level_valid <= 1'b1;
      end else if (!level_stall) begin
        level_valid <= 1'b0;
      end
    end
  end

  // Band store: one write and one registered read per array per cycle
  always_ff @(posedge clk) begin
    if (start_we) begin
      start_mem[start_waddr] <= start_wdata;
    end
    if (level_we) begin
      level_mem[band_idx] <= level_wdata;
    end
    rd_start <= start_vld[rd_addr] ? start_mem[rd_addr] : '0;
    rd_level <= level_vld[rd_addr] ? level_mem[rd_addr] : '0;
  end

  // Datapath registers
  always_ff @(posedge clk) begin
    if (state == S_IDLE && gauge_valid) begin
      pct   <= gauge_percent;
      chg   <= charging;
      now_t <= now_seconds;
    end
    if (state == S_RD_PREV) begin
      cur_start <= rd_start;
      cur_level <= rd_level;
    end
    if (state == S_DIFF) begin
      elapsed  <= now_t - cur_start;
      ref_span <= cur_start - rd_start;
    end
    if (state == S_DIV1) begin
      // Minutes times 100 as shifts and adds
      prod <= DIV_W'({div_rsp.quot, 6'b0}) + DIV_W'({div_rsp.quot, 5'b0})
            + DIV_W'({div_rsp.quot, 2'b0});
    end
    if (res_ld) begin
      res_level <= res_next;
    end
    if (out_ld) begin
      level_hundredths <= LEVEL_W'(LEVEL_W'(res_level) * LEVEL_W'(PCT_SCALE));
    end
  end

endmodule

### sim/battery_level_top_band_smoother_tb.sv
// Self-checking testbench for the top-band battery level smoother.
module battery_level_top_band_smoother_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import bltbs_pkg::*;

  localparam int LIMIT_CYCLES = 1_200_000;
  localparam int PHASE_ITEMS  = 300;

  // Expected display levels, kept by a private copy of the band store
  class band_level_board;
    bit [TIME_W-1:0] start_t[BAND_ENTRIES];
    bit [PCT_W-1:0]  lvl[BAND_ENTRIES];
    bit [PCT_W-1:0]  last_pct;
    bit [HOLD_W-1:0] hold;
    bit [RT_W-1:0]   runtime;
    bit [LEVEL_W-1:0] levels_due[$];
    int errors;

    function new();
      foreach (start_t[i]) begin
        start_t[i] = '0;
        lvl[i] = '0;
      end
      last_pct = '0;
      hold = HOLD_RESET;
      runtime = RUNTIME_RESET;
      errors = 0;
    endfunction

    function void set_reg(cfg_reg_t idx, bit [CFG_DATA_W-1:0] data);
      case (idx)
        REG_STEP_HOLD:    hold = data[HOLD_W-1:0];
        REG_FULL_RUNTIME: runtime = data[RT_W-1:0];
        default: ;
      endcase
    endfunction

    // Level shown for one reading; updates the band store
    function bit [LEVEL_W-1:0] smooth_level(bit [PCT_W-1:0] p, bit chg, bit [TIME_W-1:0] now);
      int unsigned r;
      bit [TIME_W-1:0] ref_gap, elapsed, twice;
      bit [63:0] minutes, rt, drop, nl;
      bit [PCT_W-1:0] shown;
      bit [LEVEL_W-1:0] wide;
      if (!chg && p == 0) begin
        shown = EMPTY_SHOWN;
      end else if (p >= 100) begin
        shown = FULL_PCT;
      end else if (p < 90) begin
        shown = p;
      end else begin
        r = 32'(p) - 32'd90;
        if (chg) begin
          if (last_pct != p) begin
            // fresh percent: restart its band
            start_t[r] = now;
            lvl[r] = p;
            last_pct = p;
            shown = p;
          end else begin
            if (r < 2) begin
              elapsed = now - start_t[r];
              if (elapsed > hold) begin
                start_t[r] = now;
                lvl[r] = lvl[r] + 7'd1;
              end
            end else begin
              // compare with the previous band's duration
              ref_gap = start_t[r] - start_t[r-1];
              elapsed = now - start_t[r];
              twice = ref_gap << 1;
              if (elapsed > ref_gap && elapsed > twice) begin
                start_t[r] = now;
                start_t[r-1] = now - ref_gap;
                lvl[r] = lvl[r] + 7'd1;
              end
            end
            if (lvl[r] > 100) lvl[r] = 100;
            shown = lvl[r];
          end
        end else if (lvl[r] > p) begin
          // discharging: decay the raised level, floored at the gauge
          elapsed = now - start_t[r];
          minutes = 64'(elapsed / 32'd60);
          rt = (runtime == 0) ? 64'd1 : 64'(runtime);
          drop = (minutes * 100 + rt - 1) / rt;
          nl = (drop >= lvl[r]) ? 64'd0 : 64'(lvl[r]) - drop;
          if (nl < 64'(p)) nl = 64'(p);
          lvl[r] = nl[PCT_W-1:0];
          shown = lvl[r];
        end else begin
          shown = p;
        end
      end
      wide = LEVEL_W'(shown);
      return wide * 14'd100;
    endfunction

    function void note_reading(bit [PCT_W-1:0] p, bit chg, bit [TIME_W-1:0] now);
      levels_due.push_back(smooth_level(p, chg, now));
    endfunction

    task report(string what);
      $display("mismatch at %0t: %s", $realtime, what);
      errors++;
    endtask

    task check_level(bit [LEVEL_W-1:0] got);
      bit [LEVEL_W-1:0] want;
      if (levels_due.size() == 0) begin
        report($sformatf("level_hundredths %0d with no reading pending", got));
      end else begin
        want = levels_due.pop_front();
        if (got !== want)
          report($sformatf("level_hundredths %0d, expected %0d", got, want));
      end
    endtask

    function int pending();
      return levels_due.size();
    endfunction
  endclass

  logic clk;
  logic rst;
  logic gauge_valid;
  logic gauge_stall;
  logic [PCT_W-1:0] gauge_percent;
  logic charging;
  logic [TIME_W-1:0] now_seconds;
  logic level_valid;
  logic level_stall;
  logic [LEVEL_W-1:0] level_hundredths;
  logic cfg_valid;
  logic cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [CFG_DATA_W-1:0] cfg_data;

  band_level_board board;
  bit calm;
  bit [TIME_W-1:0] clock_s;

  battery_level_top_band_smoother uut (
    .clk(clk),
    .rst(rst),
    .gauge_valid(gauge_valid),
    .gauge_stall(gauge_stall),
    .gauge_percent(gauge_percent),
    .charging(charging),
    .now_seconds(now_seconds),
    .level_valid(level_valid),
    .level_stall(level_stall),
    .level_hundredths(level_hundredths),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data)
  );

  initial clk = 1'b0;
  always #4 clk = ~clk;

  // Gap length: none while calm, else mostly none or short, a few long
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (calm) return 0;
    if (r < 50) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  // Transaction monitor
  always @(posedge clk) begin
    if (!rst) begin
      if (gauge_valid && !gauge_stall)
        board.note_reading(gauge_percent, charging, now_seconds);
      if (level_valid && !level_stall)
        board.check_level(level_hundredths);
    end
  end

  // Result side back-pressure
  initial begin
    level_stall = 1'b0;
    @(negedge clk);
    while (rst) @(negedge clk);
    forever begin
      int n;
      n = pick_gap();
      if (n > 0) begin
        level_stall <= 1'b1;
        repeat (n) @(negedge clk);
      end
      level_stall <= 1'b0;
      repeat ($urandom_range(1, 6)) @(negedge clk);
    end
  end

  // Watchdog
  initial begin
    repeat (LIMIT_CYCLES) @(posedge clk);
    $display("[battery_level_top_band_smoother] ERROR");
    $finish;
  end

  // Called at a falling edge; returns at a falling edge with valid still high
  task send_reading(input bit [PCT_W-1:0] p, input bit chg, input bit [TIME_W-1:0] t);
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      gauge_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    gauge_valid <= 1'b1;
    gauge_percent <= p;
    charging <= chg;
    now_seconds <= t;
    do @(posedge clk); while (gauge_stall);
    @(negedge clk);
  endtask

  // Hold off the sender until every expected level has arrived
  task wait_drained();
    gauge_valid <= 1'b0;
    @(negedge clk);
    while (board.pending() > 0) @(negedge clk);
    repeat (4) @(negedge clk);
  endtask

  task write_reg(input cfg_reg_t idx, input bit [CFG_DATA_W-1:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    do @(posedge clk); while (!cfg_ready);
    board.set_reg(idx, data);
    @(negedge clk);
    cfg_valid <= 1'b0;
    @(negedge clk);
  endtask

  // Random readings: charge ramps, discharge runs and noise
  task random_phase(input int n);
    int done;
    int kind;
    int unsigned span;
    bit [PCT_W-1:0] pct;
    bit [PCT_W-1:0] lowest;
    done = 0;
    while (done < n) begin
      kind = $urandom_range(0, 99);
      case ($urandom_range(0, 3))
        0: span = 20;
        1: span = 2000;
        2: span = 100000;
        default: span = 32'h0100_0000;
      endcase
      if ($urandom_range(0, 7) == 0)
        clock_s = 32'hFFFF_FFFF - $urandom_range(0, 50000);
      else if ($urandom_range(0, 3) == 0)
        clock_s = $urandom;
      if (kind < 45) begin
        // charging upward through the band, with an odd glitch
        pct = PCT_W'($urandom_range(86, 99));
        while (pct <= 100 && done < n) begin
          repeat ($urandom_range(1, 6)) begin
            clock_s += $urandom_range(0, span);
            if ($urandom_range(0, 19) == 0)
              send_reading(PCT_W'($urandom_range(0, 127)), 1'($urandom_range(0, 1)),
                           clock_s);
            else
              send_reading(pct, 1'b1, clock_s);
            done++;
          end
          pct++;
        end
      end else if (kind < 80) begin
        // discharging downward
        pct = PCT_W'($urandom_range(90, 100));
        lowest = PCT_W'($urandom_range(84, 92));
        while (pct >= lowest && done < n) begin
          repeat ($urandom_range(1, 4)) begin
            clock_s += $urandom_range(0, span);
            send_reading(pct, 1'b0, clock_s);
            done++;
          end
          pct--;
        end
      end else begin
        repeat ($urandom_range(1, 5)) begin
          send_reading(PCT_W'($urandom_range(0, 127)), 1'($urandom_range(0, 1)), $urandom);
          done++;
        end
      end
      if (done >= n / 2 && done < n / 2 + 6) wait_drained();
    end
  endtask

  initial begin
    board = new();
    calm = 1'b0;
    clock_s = '0;
    rst = 1'b1;
    gauge_valid = 1'b0;
    gauge_percent = '0;
    charging = 1'b0;
    now_seconds = '0;
    cfg_valid = 1'b0;
    cfg_index = REG_STEP_HOLD;
    cfg_data = '0;
    repeat (10) @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // Directed: empty, full, above full, below band
    send_reading(7'd0, 1'b0, 32'd5);
    send_reading(7'd0, 1'b1, 32'd5);
    send_reading(7'd100, 1'b0, 32'd5);
    send_reading(7'd127, 1'b1, 32'd5);
    send_reading(7'd101, 1'b0, 32'd5);
    send_reading(7'd89, 1'b1, 32'd5);
    // hold rule in the two lowest bands, at and past the hold time
    send_reading(7'd90, 1'b1, 32'd1000);
    send_reading(7'd90, 1'b1, 32'd2800);
    send_reading(7'd90, 1'b1, 32'd2801);
    send_reading(7'd91, 1'b1, 32'd3000);
    send_reading(7'd91, 1'b1, 32'd4801);
    // twice-previous-duration rule
    send_reading(7'd92, 1'b1, 32'd5000);
    send_reading(7'd92, 1'b1, 32'd5300);
    send_reading(7'd92, 1'b1, 32'd5500);
    // cap at full
    send_reading(7'd99, 1'b1, 32'd6000);
    send_reading(7'd99, 1'b1, 32'd18001);
    send_reading(7'd99, 1'b1, 32'd30002);
    // discharge decay, floor at gauge, zero minutes, time wrap
    send_reading(7'd99, 1'b0, 32'd18601);
    send_reading(7'd92, 1'b0, 32'd5560);
    send_reading(7'd91, 1'b0, 32'd4860);
    send_reading(7'd91, 1'b0, 32'd4800);
    send_reading(7'd90, 1'b0, 32'd0);
    send_reading(7'd95, 1'b1, 32'd7);
    send_reading(7'd95, 1'b1, 32'd3);
    send_reading(7'd50, 1'b0, 32'd1);

    // Register settings, extremes included
    wait_drained();
    write_reg(REG_STEP_HOLD, 17'd1);
    write_reg(REG_FULL_RUNTIME, 17'd1);
    random_phase(PHASE_ITEMS);

    wait_drained();
    write_reg(REG_STEP_HOLD, 17'd86400);
    write_reg(REG_FULL_RUNTIME, 17'd65535);
    calm = 1'b1;
    random_phase(PHASE_ITEMS / 2);
    calm = 1'b0;
    random_phase(PHASE_ITEMS / 2);

    // all-ones hold; runtime data with only the unused top bit set reads as zero
    wait_drained();
    write_reg(REG_STEP_HOLD, 17'h1FFFF);
    write_reg(REG_FULL_RUNTIME, 17'h10000);
    random_phase(PHASE_ITEMS);

    wait_drained();
    write_reg(REG_STEP_HOLD, CFG_DATA_W'($urandom_range(1, 86400)));
    write_reg(REG_FULL_RUNTIME, CFG_DATA_W'($urandom_range(1, 2000)));
    random_phase(PHASE_ITEMS);

    wait_drained();
    write_reg(REG_STEP_HOLD, 17'd0);
    write_reg(REG_FULL_RUNTIME, CFG_DATA_W'($urandom_range(1, 65535)));
    random_phase(PHASE_ITEMS);

    // Drain and settle
    wait_drained();
    repeat (100) @(posedge clk);
    if (board.errors == 0 && board.pending() == 0)
      $display("[battery_level_top_band_smoother] OK");
    else
      $display("[battery_level_top_band_smoother] ERROR");
    $finish;
  end

endmodule

### files.f
rtl/core/bltbs_pkg.sv
rtl/core/bltbs_div.sv
rtl/core/battery_level_top_band_smoother.sv
sim/battery_level_top_band_smoother_tb.sv
